// ===== design/lfx_pkg.sv =====
// Shared types, codes and arithmetic helpers for the LED effect renderer.
`default_nettype none
package lfx_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam logic [6:0] FULL_PCT = 7'd100;
    localparam logic [7:0] DEFAULT_PERIOD = 8'd20;
    localparam logic [7:0] HUE_WRAP = 8'd192;
    localparam logic [6:0] RAINBOW_MAX_STEPS = 7'd64;
    localparam logic [7:0] BREATH_MAX_STEPS = 8'd200;
    localparam logic [12:0] RECIP_100 = 13'd5243;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_KEY    = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_NONE   = 2'd3
    } lfx_cmd_t;

    typedef enum logic [1:0] {
        PM_OFF     = 2'd0,
        PM_STATIC  = 2'd1,
        PM_BREATH  = 2'd2,
        PM_RAINBOW = 2'd3
    } lfx_pmode_t;

    typedef enum logic [1:0] {
        AM_NOTHING = 2'd0,
        AM_SOLID   = 2'd1,
        AM_OFF     = 2'd2,
        AM_UNUSED  = 2'd3
    } lfx_amode_t;

    typedef enum logic [2:0] {
        REG_LED_COUNT   = 3'd0,
        REG_BRIGHTNESS  = 3'd1,
        REG_RB_PERIOD   = 3'd2,
        REG_BR_PERIOD   = 3'd3,
        REG_BR_FLOOR    = 3'd4,
        REG_REVERSED    = 3'd5,
        REG_SPARE6      = 3'd6,
        REG_SPARE7      = 3'd7
    } lfx_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_SETUP,
        ST_STEP,
        ST_RENDER,
        ST_DRAIN
    } lfx_state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  led_index;
        logic        pressed;
        logic [1:0]  passive_mode;
        logic [1:0]  active_mode;
        logic [7:0]  passive_red;
        logic [7:0]  passive_green;
        logic [7:0]  passive_blue;
        logic [7:0]  active_red;
        logic [7:0]  active_green;
        logic [7:0]  active_blue;
        logic [31:0] now_ms;
    } lfx_in_t;

    typedef struct packed {
        logic [3:0] physical_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } lfx_out_t;

    typedef struct packed {
        logic [1:0]  pm;
        logic [1:0]  am;
        logic [23:0] prgb;
        logic [23:0] argb;
    } lfx_entry_t;

    // Exact x/100 for x up to 25500 via reciprocal multiply.
    function automatic logic [7:0] div100(input logic [14:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'(RECIP_100);
        return p[26:19];
    endfunction

endpackage
`default_nettype wire

// ===== design/led_effect_renderer.sv =====
// LED effect renderer top: command decode, config registers, sequencer.
// An update holds busy while it scans the table, steps the effects (rainbow up
// to 64 steps, breathing up to 200, in parallel) and renders the LEDs.
// Results come out one LED per cycle, each shown for one cycle; no stall. Writes
// and key commands are taken only while idle. Reset clears key flags and effect
// state and restores config defaults; table entries are undefined until written.
`default_nettype none
module led_effect_renderer #(
    parameter int MAX_LEDS  = 16,
    parameter int HUE_SHIFT = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire lfx_pkg::lfx_in_t item,
    output logic                 result_valid,
    output lfx_pkg::lfx_out_t    result,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [4:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import lfx_pkg::*;

    localparam logic [4:0] CAP = (MAX_LEDS < TABLE_DEPTH) ? 5'(MAX_LEDS) : 5'(TABLE_DEPTH);

    lfx_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [4:0] led_count_reg;
    logic [7:0] bright_reg, rb_per_reg, br_per_reg, floor_reg;
    logic       rev_reg;
    logic [15:0] keys_reg;
    logic       has_rb_reg, has_br_reg, scan_v_reg;
    logic [31:0] now_reg;

    logic [4:0] count;
    logic       accept, cfg_wr, go, issue, issue_last, step_busy, rend_busy;
    logic [3:0] raddr;
    lfx_entry_t wentry, rentry;
    lfx_reg_t   cfg_idx;
    logic [7:0] phase;
    logic [6:0] level;

    assign count   = (led_count_reg < CAP) ? led_count_reg : CAP;
    assign accept  = start && (state_reg == ST_IDLE);
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = lfx_reg_t'(paddr[4:2]);
    assign pready  = 1'b1;
    assign busy    = (state_reg != ST_IDLE);
    assign wentry  = '{pm: item.passive_mode, am: item.active_mode,
                       prgb: {item.passive_red, item.passive_green, item.passive_blue},
                       argb: {item.active_red, item.active_green, item.active_blue}};

    always_comb
    begin
        unique case (cfg_idx)
            REG_LED_COUNT:  prdata = 32'(led_count_reg);
            REG_BRIGHTNESS: prdata = 32'(bright_reg);
            REG_RB_PERIOD:  prdata = 32'(rb_per_reg);
            REG_BR_PERIOD:  prdata = 32'(br_per_reg);
            REG_BR_FLOOR:   prdata = 32'(floor_reg);
            REG_REVERSED:   prdata = 32'(rev_reg);
            default:        prdata = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept && item.command == CMD_UPDATE && count != 5'd0)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == count - 5'd1)
                    state_next = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT: state_next = ST_SETUP;
            ST_SETUP:     state_next = ST_STEP;
            ST_STEP:
            begin
                cnt_next = '0;
                if (!step_busy)
                    state_next = ST_RENDER;
            end
            ST_RENDER:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == count - 5'd1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!rend_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        go         = 1'b0;
        issue      = 1'b0;
        issue_last = 1'b0;
        unique case (state_reg)
            ST_SETUP:  go = 1'b1;
            ST_RENDER:
            begin
                issue      = 1'b1;
                issue_last = (cnt_reg == count - 5'd1);
            end
            default: ;
        endcase
    end

    assign raddr = cnt_reg[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            led_count_reg <= 5'd16;
            bright_reg    <= 8'd100;
            rb_per_reg    <= '0;
            br_per_reg    <= '0;
            floor_reg     <= '0;
            rev_reg       <= 1'b0;
            keys_reg      <= '0;
            has_rb_reg    <= 1'b0;
            has_br_reg    <= 1'b0;
            scan_v_reg    <= 1'b0;
            now_reg       <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            scan_v_reg <= (state_reg == ST_SCAN);
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_LED_COUNT:  led_count_reg <= pwdata[4:0];
                    REG_BRIGHTNESS: bright_reg    <= pwdata[7:0];
                    REG_RB_PERIOD:  rb_per_reg    <= pwdata[7:0];
                    REG_BR_PERIOD:  br_per_reg    <= pwdata[7:0];
                    REG_BR_FLOOR:   floor_reg     <= pwdata[7:0];
                    REG_REVERSED:   rev_reg       <= pwdata[0];
                    default: ;
                endcase
            end
            if (accept && item.command == CMD_KEY && 5'(item.led_index) < count)
                keys_reg[item.led_index] <= item.pressed;
            if (accept && item.command == CMD_UPDATE)
            begin
                has_rb_reg <= 1'b0;
                has_br_reg <= 1'b0;
                now_reg    <= item.now_ms;
            end
            else if (scan_v_reg)
            begin
                if (rentry.pm == PM_RAINBOW)
                    has_rb_reg <= 1'b1;
                if (rentry.pm == PM_BREATH)
                    has_br_reg <= 1'b1;
            end
        end
    end

    lfx_table u_table (
        .clk   (clk),
        .we    (accept && item.command == CMD_WRITE && 5'(item.led_index) < CAP),
        .waddr (item.led_index),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rentry)
    );

    lfx_stepper u_stepper (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .has_rb    (has_rb_reg),
        .has_br    (has_br_reg),
        .now       (now_reg),
        .rb_period (rb_per_reg),
        .br_period (br_per_reg),
        .br_floor  (floor_reg),
        .busy      (step_busy),
        .phase     (phase),
        .level     (level)
    );

    lfx_render #(
        .MAX_LEDS  (MAX_LEDS),
        .HUE_SHIFT (HUE_SHIFT)
    ) u_render (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .issue_idx    (raddr),
        .issue_last   (issue_last),
        .entry        (rentry),
        .keys         (keys_reg),
        .phase        (phase),
        .level        (level),
        .brightness   (bright_reg),
        .reversed     (rev_reg),
        .busy         (rend_busy),
        .result_valid (result_valid),
        .result       (result)
    );
endmodule
`default_nettype wire

// ===== design/lfx_table.sv =====
// Per-LED mode and color memory, one write port and one registered read port.
`default_nettype none
module lfx_table (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [3:0]        waddr,
    input  wire lfx_pkg::lfx_entry_t wdata,
    input  wire logic [3:0]        raddr,
    output lfx_pkg::lfx_entry_t    rdata
);
    import lfx_pkg::*;

    lfx_entry_t mem [TABLE_DEPTH];
    lfx_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== design/lfx_stepper.sv =====
// Rainbow phase and breathing level stepping, one step of each per cycle while pending time allows.
`default_nettype none
module lfx_stepper (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic        has_rb,
    input  wire logic        has_br,
    input  wire logic [31:0] now,
    input  wire logic [7:0]  rb_period,
    input  wire logic [7:0]  br_period,
    input  wire logic [7:0]  br_floor,
    output logic             busy,
    output logic [7:0]       phase,
    output logic [6:0]       level
);
    import lfx_pkg::*;

    logic [15:0] rb_rem_reg, br_rem_reg;
    logic [6:0]  rb_cnt_reg;
    logic [7:0]  br_cnt_reg;
    logic        rb_on_reg, br_on_reg, run_reg;
    logic [31:0] now_reg, last_rb_reg, last_br_reg;
    logic [7:0]  phase_reg;
    logic [6:0]  level_reg;
    logic        falling_reg;
    logic [7:0]  rb_per, br_per;
    logic [6:0]  floor_c;
    logic        rb_act, br_act;
    logic [31:0] rb_diff, br_diff;

    always_comb
    begin
        rb_per  = (rb_period == 8'd0) ? DEFAULT_PERIOD : rb_period;
        br_per  = (br_period == 8'd0) ? DEFAULT_PERIOD : br_period;
        floor_c = (br_floor > 8'(FULL_PCT)) ? FULL_PCT : br_floor[6:0];
        rb_act  = run_reg && rb_on_reg && (rb_rem_reg >= 16'(rb_per))
                  && (rb_cnt_reg < RAINBOW_MAX_STEPS);
        br_act  = run_reg && br_on_reg && (br_rem_reg >= 16'(br_per))
                  && (br_cnt_reg < BREATH_MAX_STEPS);
        rb_diff = now - last_rb_reg;
        br_diff = now - last_br_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            rb_on_reg   <= 1'b0;
            br_on_reg   <= 1'b0;
            rb_rem_reg  <= '0;
            br_rem_reg  <= '0;
            rb_cnt_reg  <= '0;
            br_cnt_reg  <= '0;
            now_reg     <= '0;
            last_rb_reg <= '0;
            last_br_reg <= '0;
            phase_reg   <= '0;
            level_reg   <= FULL_PCT;
            falling_reg <= 1'b1;
        end
        else if (go)
        begin
            run_reg    <= 1'b1;
            rb_on_reg  <= has_rb;
            br_on_reg  <= has_br;
            rb_rem_reg <= rb_diff[15:0];
            br_rem_reg <= br_diff[15:0];
            rb_cnt_reg <= '0;
            br_cnt_reg <= '0;
            now_reg    <= now;
        end
        else if (run_reg)
        begin
            if (rb_act)
            begin
                rb_rem_reg <= rb_rem_reg - 16'(rb_per);
                rb_cnt_reg <= rb_cnt_reg + 7'd1;
                phase_reg  <= (phase_reg == HUE_WRAP - 8'd1) ? 8'd0 : phase_reg + 8'd1;
            end
            if (br_act)
            begin
                br_rem_reg <= br_rem_reg - 16'(br_per);
                br_cnt_reg <= br_cnt_reg + 8'd1;
                if (falling_reg)
                begin
                    if (level_reg > floor_c)
                        level_reg <= level_reg - 7'd1;
                    else
                        falling_reg <= 1'b0;
                end
                else
                begin
                    if (level_reg < FULL_PCT)
                        level_reg <= level_reg + 7'd1;
                    else
                        falling_reg <= 1'b1;
                end
            end
            if (!rb_act && !br_act)
            begin
                run_reg <= 1'b0;
                // leftover time stays pending
                if (rb_cnt_reg != 7'd0)
                    last_rb_reg <= now_reg - 32'(rb_rem_reg);
                if (br_cnt_reg != 8'd0)
                    last_br_reg <= now_reg - 32'(br_rem_reg);
            end
        end
    end

    assign busy  = run_reg;
    assign phase = phase_reg;
    assign level = level_reg;
endmodule
`default_nettype wire

// ===== design/lfx_render.sv =====
// Color selection and brightness scaling pipeline, one LED per cycle.
`default_nettype none
module lfx_render #(
    parameter int MAX_LEDS  = 16,
    parameter int HUE_SHIFT = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                issue,
    input  wire logic [3:0]          issue_idx,
    input  wire logic                issue_last,
    input  wire lfx_pkg::lfx_entry_t entry,
    input  wire logic [15:0]         keys,
    input  wire logic [7:0]          phase,
    input  wire logic [6:0]          level,
    input  wire logic [7:0]          brightness,
    input  wire logic                reversed,
    output logic                     busy,
    output logic                     result_valid,
    output lfx_pkg::lfx_out_t        result
);
    import lfx_pkg::*;

    localparam logic [6:0] LAST_PHYS = 7'(MAX_LEDS - 1);
    localparam logic [9:0] HUE_FULL = 10'(63 << HUE_SHIFT);

    logic        va_reg, vb_reg, vc_reg, vd_reg, vo_reg;
    logic [3:0]  ia_reg;
    logic        la_reg;
    logic [3:0]  pb_reg, pc_reg, pd_reg;
    logic        lb_reg, lc_reg, ld_reg;
    logic [23:0] rgbb_reg, rgbc_reg;
    logic [13:0] prodb_reg;
    logic [6:0]  effc_reg;
    logic [14:0] rd_reg, gd_reg, bd_reg;
    lfx_out_t    out_reg;

    logic [8:0]  hsum;
    logic [7:0]  hue, s8, n8;
    logic [9:0]  s10, n10;
    logic [23:0] hue_rgb, rgb_sel;
    logic [6:0]  pct, gb_c, phys7;
    logic [13:0] eff_wide;
    logic [7:0]  eff8;

    always_comb
    begin
        hsum = {1'b0, phase} + {2'b0, ia_reg, 3'b0};
        hue  = (hsum >= 9'(HUE_WRAP)) ? 8'(hsum - 9'(HUE_WRAP)) : hsum[7:0];
        s10  = 10'(hue[5:0]) << HUE_SHIFT;
        s8   = s10[7:0];
        n10  = HUE_FULL - {2'b0, s8};
        n8   = n10[7:0];
        case (hue[7:6])
            2'd0:    hue_rgb = {n8, s8, 8'd0};
            2'd1:    hue_rgb = {8'd0, n8, s8};
            default: hue_rgb = {s8, 8'd0, n8};
        endcase

        pct = FULL_PCT;
        if (keys[ia_reg] && entry.am == AM_SOLID)
            rgb_sel = entry.argb;
        else if (keys[ia_reg] && entry.am == AM_OFF)
            rgb_sel = '0;
        else
        begin
            case (entry.pm)
                PM_OFF:    rgb_sel = '0;
                PM_STATIC: rgb_sel = entry.prgb;
                PM_BREATH:
                begin
                    rgb_sel = entry.prgb;
                    pct     = level;
                end
                default:   rgb_sel = hue_rgb;
            endcase
        end

        gb_c     = (brightness > 8'(FULL_PCT)) ? FULL_PCT : brightness[6:0];
        phys7    = reversed ? (LAST_PHYS - {3'b0, ia_reg}) : {3'b0, ia_reg};
        eff_wide = prodb_reg;
        eff8     = div100({1'b0, eff_wide});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            va_reg <= issue;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            vo_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ia_reg    <= issue_idx;
        la_reg    <= issue_last;
        // pick color and percent, multiply by brightness
        pb_reg    <= phys7[3:0];
        lb_reg    <= la_reg;
        rgbb_reg  <= rgb_sel;
        prodb_reg <= 14'(pct) * 14'(gb_c);
        // effective percent
        pc_reg    <= pb_reg;
        lc_reg    <= lb_reg;
        rgbc_reg  <= rgbb_reg;
        effc_reg  <= eff8[6:0];
        // scale each component
        pd_reg    <= pc_reg;
        ld_reg    <= lc_reg;
        rd_reg    <= 15'(rgbc_reg[23:16]) * 15'(effc_reg);
        gd_reg    <= 15'(rgbc_reg[15:8]) * 15'(effc_reg);
        bd_reg    <= 15'(rgbc_reg[7:0]) * 15'(effc_reg);
        out_reg.physical_index <= pd_reg;
        out_reg.red            <= div100(rd_reg);
        out_reg.green          <= div100(gd_reg);
        out_reg.blue           <= div100(bd_reg);
        out_reg.last           <= ld_reg;
    end

    assign busy         = va_reg | vb_reg | vc_reg | vd_reg;
    assign result_valid = vo_reg;
    assign result       = out_reg;
endmodule
`default_nettype wire
